[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the checker modules.
// Both macros take the clock and the synchronous reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When cond holds at an edge, expr must hold at the next edge.
`define CHK_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

[hw/rtl/rgbyuv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Types, constants and helper functions of the RGB to YUV 4:2:0 writer.
// ----------------------------------------------------------------------------
package rgbyuv_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int ADDR_W      = 25;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAYOUT_MODE  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic                  RESET_LAYOUT = 1'b0;

  localparam logic LAYOUT_INTERLEAVED = 1'b0;
  localparam logic LAYOUT_PLANAR      = 1'b1;

  // Plane codes carried on each output beat.
  localparam logic [1:0] PLANE_LUMA = 2'd0;
  localparam logic [1:0] PLANE_U    = 2'd1;
  localparam logic [1:0] PLANE_V    = 2'd2;

  // BT.601 integer matrix.
  localparam int COEF_Y_R = 66;
  localparam int COEF_Y_G = 129;
  localparam int COEF_Y_B = 25;
  localparam int COEF_U_R = -38;
  localparam int COEF_U_G = -74;
  localparam int COEF_U_B = 112;
  localparam int COEF_V_R = 112;
  localparam int COEF_V_G = -94;
  localparam int COEF_V_B = -18;
  localparam int ROUND_BIAS = 128;
  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  localparam int SUM_W = 18;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        byte_value;
    logic [1:0]        plane_kind;
    logic              last_of_pixel;
    logic              frame_done;
  } result_t;

  // One converted pixel waiting to be written out.
  typedef struct packed {
    logic [7:0]        y;
    logic [7:0]        u;
    logic [7:0]        v;
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] first_addr;
    logic [ADDR_W-1:0] second_addr;
    logic              chroma;
    logic              done;
    logic              layout;
  } entry_t;

  // Floor shift of a matrix sum by 8, add the offset, clamp to a byte.
  function automatic logic [7:0] sat_byte(input logic signed [SUM_W-1:0] sum,
                                          input logic [7:0] offs);
    logic signed [10:0] t;
    t = 11'(sum >>> 8) + $signed({3'b000, offs});
    if (t < 0) begin
      return 8'd0;
    end else if (t > 11'sd255) begin
      return 8'd255;
    end
    return t[7:0];
  endfunction

endpackage

[hw/rtl/rgb_to_yuv420_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_yuv420_writer
// Streaming RGB to YUV 4:2:0 converter that emits frame buffer byte writes.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Beat contents
//   in        in_valid / in_stall     one RGB pixel, raster order
//   out       out_valid / out_stall   one byte write: address, value, plane
//   cfg       cfg_valid / cfg_ready   register index and write data
//
// Each output beat is one byte; the output side moves one beat per cycle
// unless out_stall holds it. A pixel on an even row and even column makes
// three beats and any other pixel makes one: two beats per pixel along an
// even row and one and a half over a whole frame, paced by the single
// output register. A lone pixel's luma beat passes through the staging
// register, the queue and the output register. After reset and after every
// write to a defined register, input is held off while the frame restarts.
// The four-entry queue absorbs output stalls; input flows until it fills.
//
// Pixels are converted with the integer BT.601 matrix: the weighted sum plus
// 128 is floor-shifted right by 8, offset (16 for luma, 128 for chroma) and
// clamped to a byte. Chroma is sampled from the top-left pixel of each 2x2
// block, with no averaging. Layout 0 places an interleaved V,U plane after
// the luma plane; layout 1 places a quarter-size U plane then a V plane.
// The counters and pointers wrap to the next frame after its last pixel,
// and every write to a defined register restarts the frame.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_writer #(
  parameter int MAX_WIDTH  = rgbyuv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbyuv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rgbyuv_pkg::pixel_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rgbyuv_pkg::result_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgbyuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbyuv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic               push;
  logic               full;
  logic               pop;
  logic               head_valid;
  rgbyuv_pkg::entry_t push_entry;
  rgbyuv_pkg::entry_t head;

  // Registers are always writable; the host must write only while idle.
  assign cfg_ready = 1'b1;

  // Front: configuration, raster counters, write pointers and matrix sums.
  rgbyuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  // Queue that lets the front keep accepting while the output is stalled.
  rgbyuv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: one byte beat per cycle into the output register unless stalled.
  rgbyuv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[hw/rtl/rgbyuv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyuv_front
// Accepts pixels, holds the configuration, the raster counters and the write
// pointers, forms the matrix sums and hands finished entries to the queue.
// ----------------------------------------------------------------------------
module rgbyuv_front #(
  parameter int MAX_WIDTH  = rgbyuv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbyuv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rgbyuv_pkg::pixel_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [rgbyuv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgbyuv_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                push,
  output rgbyuv_pkg::entry_t                  push_entry,
  input  logic                                full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = CW + 1;
  localparam int HW = RW + 1;
  localparam int AW = WW + HW;
  localparam int AD = rgbyuv_pkg::ADDR_W;
  localparam int SW = rgbyuv_pkg::SUM_W;
  localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);
  localparam logic [13:0] MAX_H14 = 14'(MAX_HEIGHT);

  logic [rgbyuv_pkg::CFG_DATA_W-1:0] frame_width;
  logic [rgbyuv_pkg::CFG_DATA_W-1:0] frame_height;
  logic                              layout_mode;
  logic                              settle;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [AD-1:0] luma_pointer;
  logic [AD-1:0] chroma_pointer;
  logic [AW-1:0] area;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [AW-1:0] area_now;
  logic [AD-1:0] quarter;
  logic          last_col;
  logic          last_row;
  logic          chroma;
  logic          done;
  logic          accept;
  logic          cfg_hit;

  logic signed [8:0]    r_s;
  logic signed [8:0]    g_s;
  logic signed [8:0]    b_s;
  logic signed [SW-1:0] y_sum;
  logic signed [SW-1:0] u_sum;
  logic signed [SW-1:0] v_sum;

  // Staging register between acceptance and the queue.
  logic                 a_valid;
  logic signed [SW-1:0] a_ysum;
  logic signed [SW-1:0] a_usum;
  logic signed [SW-1:0] a_vsum;
  logic [AD-1:0]        a_luma;
  logic [AD-1:0]        a_first;
  logic [AD-1:0]        a_second;
  logic                 a_chroma;
  logic                 a_done;
  logic                 a_layout;

  // Sizes are forced even and into 2..MAX.
  always_comb begin
    logic [13:0] w14;
    logic [13:0] h14;
    w14 = {1'b0, frame_width};
    h14 = {1'b0, frame_height};
    if (w14 < 14'd2) begin
      w14 = 14'd2;
    end else if (w14 > MAX_W14) begin
      w14 = MAX_W14;
    end
    if (h14 < 14'd2) begin
      h14 = 14'd2;
    end else if (h14 > MAX_H14) begin
      h14 = MAX_H14;
    end
    eff_w = WW'(w14 & 14'h3FFE);
    eff_h = HW'(h14 & 14'h3FFE);
  end

  assign area_now = AW'(eff_w) * AW'(eff_h);
  assign quarter  = AD'(area >> 2);

  assign last_col = ({1'b0, column_count} + WW'(1)) == eff_w;
  assign last_row = ({1'b0, row_count} + HW'(1)) == eff_h;
  assign done     = last_col & last_row;
  assign chroma   = ~column_count[0] & ~row_count[0];

  assign in_stall = settle | (a_valid & full);
  assign accept   = in_valid & ~in_stall;
  assign push     = a_valid & ~full;

  assign cfg_hit = cfg_valid & ((cfg_index == rgbyuv_pkg::CFG_FRAME_WIDTH) |
                                (cfg_index == rgbyuv_pkg::CFG_FRAME_HEIGHT) |
                                (cfg_index == rgbyuv_pkg::CFG_LAYOUT_MODE));

  always_comb begin
    r_s = $signed({1'b0, in_data.red});
    g_s = $signed({1'b0, in_data.green});
    b_s = $signed({1'b0, in_data.blue});
    y_sum = SW'(rgbyuv_pkg::COEF_Y_R * r_s + rgbyuv_pkg::COEF_Y_G * g_s +
                rgbyuv_pkg::COEF_Y_B * b_s + rgbyuv_pkg::ROUND_BIAS);
    u_sum = SW'(rgbyuv_pkg::COEF_U_R * r_s + rgbyuv_pkg::COEF_U_G * g_s +
                rgbyuv_pkg::COEF_U_B * b_s + rgbyuv_pkg::ROUND_BIAS);
    v_sum = SW'(rgbyuv_pkg::COEF_V_R * r_s + rgbyuv_pkg::COEF_V_G * g_s +
                rgbyuv_pkg::COEF_V_B * b_s + rgbyuv_pkg::ROUND_BIAS);
  end

  always_ff @(posedge clk) begin
    area <= area_now;
    if (rst) begin
      frame_width  <= rgbyuv_pkg::RESET_WIDTH;
      frame_height <= rgbyuv_pkg::RESET_HEIGHT;
      layout_mode  <= rgbyuv_pkg::RESET_LAYOUT;
      settle       <= 1'b1;
    end else begin
      settle <= cfg_hit;
      if (cfg_valid) begin
        unique case (cfg_index)
          rgbyuv_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
          rgbyuv_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          rgbyuv_pkg::CFG_LAYOUT_MODE:  layout_mode  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // A restart is taken in the cycle after reset or a write to a defined
  // register, when the new sizes have settled and input is held off.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      luma_pointer <= '0;
    end else if (settle || (accept && done)) begin
      column_count   <= '0;
      row_count      <= '0;
      luma_pointer   <= '0;
      chroma_pointer <= AD'(area_now);
    end else if (accept) begin
      luma_pointer <= luma_pointer + AD'(1);
      if (last_col) begin
        column_count <= '0;
        row_count    <= row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
      if (chroma) begin
        chroma_pointer <= chroma_pointer +
                          ((layout_mode == rgbyuv_pkg::LAYOUT_PLANAR) ? AD'(1) : AD'(2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ysum   <= y_sum;
      a_usum   <= u_sum;
      a_vsum   <= v_sum;
      a_luma   <= luma_pointer;
      a_first  <= chroma_pointer;
      a_second <= chroma_pointer +
                  ((layout_mode == rgbyuv_pkg::LAYOUT_PLANAR) ? quarter : AD'(1));
      a_chroma <= chroma;
      a_done   <= done;
      a_layout <= layout_mode;
    end
  end

  always_comb begin
    push_entry.y           = rgbyuv_pkg::sat_byte(a_ysum, rgbyuv_pkg::LUMA_OFFSET);
    push_entry.u           = rgbyuv_pkg::sat_byte(a_usum, rgbyuv_pkg::CHROMA_OFFSET);
    push_entry.v           = rgbyuv_pkg::sat_byte(a_vsum, rgbyuv_pkg::CHROMA_OFFSET);
    push_entry.luma_addr   = a_luma;
    push_entry.first_addr  = a_first;
    push_entry.second_addr = a_second;
    push_entry.chroma      = a_chroma;
    push_entry.done        = a_done;
    push_entry.layout      = a_layout;
  end

endmodule

[hw/rtl/rgbyuv_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyuv_queue
// Short first-in first-out queue of converted pixels between front and back.
// ----------------------------------------------------------------------------
module rgbyuv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rgbyuv_pkg::entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output rgbyuv_pkg::entry_t head
);

  localparam int DEPTH = rgbyuv_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  rgbyuv_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign full       = fill == NW'(DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

[hw/rtl/rgbyuv_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyuv_back
// Splits each queued pixel into its luma beat and, where present, its two
// chroma beats, one beat per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module rgbyuv_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  rgbyuv_pkg::entry_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rgbyuv_pkg::result_t out_data
);

  localparam logic [1:0] BEAT_LUMA   = 2'd0;
  localparam logic [1:0] BEAT_FIRST  = 2'd1;
  localparam logic [1:0] BEAT_SECOND = 2'd2;

  logic [1:0]          beat_idx;
  logic                load;
  logic                last_beat;
  logic                planar;
  rgbyuv_pkg::result_t beat;

  assign planar    = head.layout == rgbyuv_pkg::LAYOUT_PLANAR;
  assign load      = head_valid & (~out_valid | ~out_stall);
  assign last_beat = (beat_idx == BEAT_LUMA) ? ~head.chroma : (beat_idx == BEAT_SECOND);
  assign pop       = load & last_beat;

  // Planar layout writes U then V; interleaved writes V then U.
  always_comb begin
    beat.last_of_pixel = last_beat;
    beat.frame_done    = head.done;
    unique case (beat_idx)
      BEAT_FIRST: begin
        beat.byte_address = head.first_addr;
        beat.byte_value   = planar ? head.u : head.v;
        beat.plane_kind   = planar ? rgbyuv_pkg::PLANE_U : rgbyuv_pkg::PLANE_V;
      end
      BEAT_SECOND: begin
        beat.byte_address = head.second_addr;
        beat.byte_value   = planar ? head.v : head.u;
        beat.plane_kind   = planar ? rgbyuv_pkg::PLANE_V : rgbyuv_pkg::PLANE_U;
      end
      default: begin
        beat.byte_address = head.luma_addr;
        beat.byte_value   = head.y;
        beat.plane_kind   = rgbyuv_pkg::PLANE_LUMA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx  <= BEAT_LUMA;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat_idx  <= last_beat ? BEAT_LUMA : beat_idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= beat;
    end
  end

endmodule

[hw/rtl/rgbyuv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyuv_checker
// Port-level checks of the RGB to YUV 4:2:0 writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbyuv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input rgbyuv_pkg::pixel_t                 in_data,
  input logic                               out_valid,
  input logic                               out_stall,
  input rgbyuv_pkg::result_t                out_data,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [rgbyuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [rgbyuv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // The matrix keeps every converted byte inside the nominal video range.
  localparam logic [7:0] VALUE_MIN = 8'd16;
  localparam logic [7:0] VALUE_MAX = 8'd240;

  logic cfg_hit;
  logic unused_in;

  assign cfg_hit = cfg_valid && cfg_ready &&
                   (cfg_index == rgbyuv_pkg::CFG_FRAME_WIDTH ||
                    cfg_index == rgbyuv_pkg::CFG_FRAME_HEIGHT ||
                    cfg_index == rgbyuv_pkg::CFG_LAYOUT_MODE);
  assign unused_in = in_valid ^ (^in_data) ^ (^cfg_data);

  `CHK_NEXT(out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "output beat changed while stalled")
  `CHK_NEXT(cfg_restart_stall, clk, rst, cfg_hit, in_stall, "input not held off during frame restart")
  `CHK_ALWAYS(plane_code, clk, rst, !out_valid || out_data.plane_kind == rgbyuv_pkg::PLANE_LUMA || out_data.plane_kind == rgbyuv_pkg::PLANE_U || out_data.plane_kind == rgbyuv_pkg::PLANE_V, "unknown plane code on output")
  `CHK_ALWAYS(value_range, clk, rst, !out_valid || (out_data.byte_value >= VALUE_MIN && out_data.byte_value <= VALUE_MAX), "converted byte outside video range")

endmodule

bind rgb_to_yuv420_writer rgbyuv_checker u_checker (.*);
